### rtl/core/tcb_pkg.sv
// Package: shared constants, codes and control types of the text console buffer.
package tcb_pkg;

    localparam int MAX_COLUMNS = 128;
    localparam int MAX_ROWS    = 32;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int NCOL_W      = COL_W + 1;
    localparam int NROW_W      = ROW_W + 1;
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int DEPTH       = MAX_COLUMNS * MAX_ROWS;
    localparam int KIND_W      = 2;
    localparam int CODE_W      = 8;
    localparam int CELL_W      = 7;
    localparam int BLINK_W     = 8;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [CODE_W-1:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0]  CHAR_FIRST   = 8'd32;
    localparam logic [CODE_W-1:0]  CHAR_LAST    = 8'd127;
    localparam logic [CELL_W-1:0]  CHAR_CURSOR  = 7'd95;
    localparam logic [NCOL_W-1:0]  RST_COLUMNS  = 8'd40;
    localparam logic [NROW_W-1:0]  RST_ROWS     = 6'd20;
    localparam logic [BLINK_W-1:0] RST_BLINK    = 8'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRINT = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_TICK  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_COLUMNS    = 2'd0,
        REG_ROWS       = 2'd1,
        REG_CURSOR_EN  = 2'd2,
        REG_BLINK_RATE = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CELL_ZERO   = 2'd0,
        CELL_CURSOR = 2'd1,
        CELL_MEM    = 2'd2
    } cell_mode_t;

    typedef struct packed {
        logic take;
        logic load;
        logic busy;
    } ctrl_cmd_t;

endpackage

### rtl/core/tcb_in_if.sv
// Interface: command channel into the text console buffer.
interface tcb_in_if;
    import tcb_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [CODE_W-1:0]   char_code;
    logic [ROW_W-1:0]    read_row;
    logic [COL_W-1:0]    read_col;

    modport source (output valid, output kind, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input kind, input char_code, input read_row,
                    input read_col, output ready);
endinterface

### rtl/core/tcb_out_if.sv
// Interface: result channel out of the text console buffer.
interface tcb_out_if;
    import tcb_pkg::*;

    logic                valid;
    logic                ready;
    logic [CELL_W-1:0]   cell_res;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic                blink_on;

    modport source (output valid, output cell_res, output cursor_row, output cursor_col,
                    output blink_on, input ready);
    modport sink   (input valid, input cell_res, input cursor_row, input cursor_col,
                    input blink_on, output ready);
endinterface

### rtl/core/text_console_buffer.sv
// Top level: text console buffer with command and result channels and APB config port.
//
// Usage: each transfer on cmd carries one command (print byte, clear, read cell,
// frame tick); each command yields exactly one transfer on rsp with the read cell
// value and the cursor position and blink phase after that command.
// Result path: an accepted command reads the cell store into the registered read data;
// the result is then loaded into the rsp output registers and transfers from there.
// Throughput: one command every cycle while rsp is taken at once; the next command is
// taken in the same cycle that the previous result is loaded into the output registers.
// Clear and scroll finish in the cycle of the command: per-row fill counts mark
// which cells of a row hold data, so no clearing pass over the store runs.
// Reset: rst_n clears the console, homes the cursor, loads the register reset
// values; the block is ready for commands as soon as reset is released.
// Stall: while rsp is held, one further command is taken and then cmd.ready stays
// low until the waiting result transfers.
// Config: APB registers columns, rows, cursor_enable and blink_rate at byte
// addresses 0, 4, 8 and 12; write them only while the block is idle.
module text_console_buffer (
    input  logic                            clk,
    input  logic                            rst_n,
    tcb_in_if.sink                          cmd,
    tcb_out_if.source                       rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcb_pkg::PADDR_W-1:0]     paddr,
    input  logic [tcb_pkg::PDATA_W-1:0]     pwdata,
    output logic [tcb_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import tcb_pkg::*;

    ctrl_cmd_t ctl;

    assign pready = 1'b1;

    tcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctl       (ctl)
    );

    tcb_dpath u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .kind       (cmd.kind),
        .char_code  (cmd.char_code),
        .read_row   (cmd.read_row),
        .read_col   (cmd.read_col),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .cell_res   (rsp.cell_res),
        .cursor_row (rsp.cursor_row),
        .cursor_col (rsp.cursor_col),
        .blink_on   (rsp.blink_on)
    );

`ifndef NO_ASSERTIONS
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> ctl.busy)
        else $error("accepted command did not enter the busy state");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.busy && (!rsp.valid || rsp.ready)) |=> rsp.valid)
        else $error("pending result not presented on rsp");

    a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.busy |-> cmd.ready)
        else $error("idle block not ready for a command");
`endif

endmodule

### rtl/core/tcb_ctrl.sv
// Controller: command acceptance, result slot and output valid state.
module tcb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output tcb_pkg::ctrl_cmd_t  ctl
);
    import tcb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_BUSY = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   take;
    logic   load;

    assign out_free = !out_valid_reg || out_ready;
    assign load     = (state_reg == ST_BUSY) && out_free;
    assign in_ready = (state_reg == ST_IDLE) || load;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = ST_BUSY;
            end
            ST_BUSY:
            begin
                if (take)
                    state_next = ST_BUSY;
                else if (load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ctl.take  = take;
    assign ctl.load  = load;
    assign ctl.busy  = (state_reg == ST_BUSY);

endmodule

### rtl/core/tcb_dpath.sv
// Datapath: cell store, row fill counts, cursor, blink state and config registers.
module tcb_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tcb_pkg::ctrl_cmd_t              ctl,
    input  logic [tcb_pkg::KIND_W-1:0]      kind,
    input  logic [tcb_pkg::CODE_W-1:0]      char_code,
    input  logic [tcb_pkg::ROW_W-1:0]       read_row,
    input  logic [tcb_pkg::COL_W-1:0]       read_col,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [tcb_pkg::PADDR_W-1:0]     paddr,
    input  logic [tcb_pkg::PDATA_W-1:0]     pwdata,
    output logic [tcb_pkg::PDATA_W-1:0]     prdata,
    output logic [tcb_pkg::CELL_W-1:0]      cell_res,
    output logic [tcb_pkg::ROW_W-1:0]       cursor_row,
    output logic [tcb_pkg::COL_W-1:0]       cursor_col,
    output logic                            blink_on
);
    import tcb_pkg::*;

    logic [NCOL_W-1:0]  columns_reg, columns_next;
    logic [NROW_W-1:0]  rows_reg, rows_next;
    logic               cursor_en_reg, cursor_en_next;
    logic [BLINK_W-1:0] blink_rate_reg, blink_rate_next;
    logic [ROW_W-1:0]   top_reg, top_next;
    logic [COL_W-1:0]   x_reg, x_next;
    logic [ROW_W-1:0]   y_reg, y_next;
    logic [BLINK_W-1:0] blink_cnt_reg, blink_cnt_next;
    logic               phase_reg, phase_next;
    logic [NCOL_W-1:0]  fill_reg [MAX_ROWS];
    logic [NCOL_W-1:0]  fill_next [MAX_ROWS];

    logic [CELL_W-1:0]  mem [DEPTH];
    logic [CELL_W-1:0]  rd_data_reg;
    cell_mode_t         mode_reg;
    cell_mode_t         rd_mode;

    logic [CELL_W-1:0]  cell_res_reg;
    logic [ROW_W-1:0]   cursor_row_reg;
    logic [COL_W-1:0]   cursor_col_reg;
    logic               blink_on_reg;

    logic [NCOL_W-1:0]  nc;
    logic [NROW_W-1:0]  nr;
    logic [NROW_W-1:0]  nr_m1;
    logic [NROW_W-1:0]  cur_sum, cur_wrap;
    logic [ROW_W-1:0]   cur_phys;
    logic [NROW_W-1:0]  rd_sum, rd_wrap;
    logic [ROW_W-1:0]   rd_phys;
    logic               printable;
    logic [NCOL_W-1:0]  x_adv;
    logic               wrap;
    logic [NROW_W-1:0]  y_inc;
    logic               scroll;
    logic [NROW_W-1:0]  top_inc;
    logic [ROW_W-1:0]   top_adv;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;
    kind_t              kind_c;
    logic               clear_all;
    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;

    assign kind_c  = kind_t'(kind);
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        if (columns_reg == '0)
            nc = NCOL_W'(1);
        else if (columns_reg > NCOL_W'(MAX_COLUMNS))
            nc = NCOL_W'(MAX_COLUMNS);
        else
            nc = columns_reg;
        if (rows_reg == '0)
            nr = NROW_W'(1);
        else if (rows_reg > NROW_W'(MAX_ROWS))
            nr = NROW_W'(MAX_ROWS);
        else
            nr = rows_reg;
    end

    assign nr_m1    = nr - NROW_W'(1);
    assign cur_sum  = {1'b0, y_reg} + {1'b0, top_reg};
    assign cur_wrap = cur_sum - nr;
    assign cur_phys = (cur_sum >= nr) ? cur_wrap[ROW_W-1:0] : cur_sum[ROW_W-1:0];
    assign rd_sum   = {1'b0, read_row} + {1'b0, top_reg};
    assign rd_wrap  = rd_sum - nr;
    assign rd_phys  = (rd_sum >= nr) ? rd_wrap[ROW_W-1:0] : rd_sum[ROW_W-1:0];

    assign printable = (char_code >= CHAR_FIRST) && (char_code <= CHAR_LAST);

    always_comb
    begin
        if (printable)
            x_adv = {1'b0, x_reg} + NCOL_W'(1);
        else if (char_code == CHAR_NEWLINE)
            x_adv = nc;
        else
            x_adv = {1'b0, x_reg};
    end

    assign wrap    = (x_adv >= nc);
    assign y_inc   = {1'b0, y_reg} + NROW_W'(1);
    assign scroll  = wrap && (y_inc >= nr);
    assign top_inc = {1'b0, top_reg} + NROW_W'(1);
    assign top_adv = (top_inc >= nr) ? '0 : top_inc[ROW_W-1:0];

    always_comb
    begin
        columns_next    = columns_reg;
        rows_next       = rows_reg;
        cursor_en_next  = cursor_en_reg;
        blink_rate_next = blink_rate_reg;
        top_next        = top_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        blink_cnt_next  = blink_cnt_reg;
        phase_next      = phase_reg;
        fill_next       = fill_reg;
        clear_all       = 1'b0;

        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_COLUMNS:
                begin
                    columns_next = pwdata[NCOL_W-1:0];
                    clear_all    = 1'b1;
                end
                REG_ROWS:
                begin
                    rows_next = pwdata[NROW_W-1:0];
                    clear_all = 1'b1;
                end
                REG_CURSOR_EN:
                begin
                    cursor_en_next = pwdata[0];
                end
                REG_BLINK_RATE:
                begin
                    if (pwdata[BLINK_W-1:0] != '0)
                    begin
                        blink_rate_next = pwdata[BLINK_W-1:0];
                        blink_cnt_next  = pwdata[BLINK_W-1:0];
                        phase_next      = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (ctl.take)
        begin
            case (kind_c)
                KIND_PRINT:
                begin
                    if (printable)
                        fill_next[cur_phys] = x_adv;
                    if (wrap)
                    begin
                        x_next = '0;
                        if (scroll)
                        begin
                            fill_next[top_reg] = '0;
                            top_next           = top_adv;
                            y_next             = nr_m1[ROW_W-1:0];
                        end
                        else
                        begin
                            y_next = y_inc[ROW_W-1:0];
                        end
                    end
                    else
                    begin
                        x_next = x_adv[COL_W-1:0];
                    end
                end
                KIND_CLEAR:
                begin
                    clear_all = 1'b1;
                end
                KIND_TICK:
                begin
                    if (cursor_en_reg)
                    begin
                        if (blink_cnt_reg == '0)
                        begin
                            blink_cnt_next = blink_rate_reg;
                            phase_next     = !phase_reg;
                        end
                        else
                        begin
                            blink_cnt_next = blink_cnt_reg - BLINK_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end

        if (clear_all)
        begin
            for (int i = 0; i < MAX_ROWS; i++)
                fill_next[i] = '0;
            top_next = '0;
            x_next   = '0;
            y_next   = '0;
        end
    end

    always_comb
    begin
        rd_mode = CELL_ZERO;
        if (kind_c == KIND_READ)
        begin
            if (({1'b0, read_row} >= nr) || ({1'b0, read_col} >= nc))
                rd_mode = CELL_ZERO;
            else if (cursor_en_reg && phase_reg && (read_row == y_reg) && (read_col == x_reg))
                rd_mode = CELL_CURSOR;
            else if ({1'b0, read_col} < fill_reg[rd_phys])
                rd_mode = CELL_MEM;
            else
                rd_mode = CELL_ZERO;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg    <= RST_COLUMNS;
            rows_reg       <= RST_ROWS;
            cursor_en_reg  <= 1'b1;
            blink_rate_reg <= RST_BLINK;
            top_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            blink_cnt_reg  <= RST_BLINK;
            phase_reg      <= 1'b1;
            for (int i = 0; i < MAX_ROWS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            columns_reg    <= columns_next;
            rows_reg       <= rows_next;
            cursor_en_reg  <= cursor_en_next;
            blink_rate_reg <= blink_rate_next;
            top_reg        <= top_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            blink_cnt_reg  <= blink_cnt_next;
            phase_reg      <= phase_next;
            fill_reg       <= fill_next;
        end
    end

    assign mem_we  = ctl.take && (kind_c == KIND_PRINT) && printable;
    assign wr_addr = {cur_phys, x_reg};
    assign rd_addr = {rd_phys, read_col};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= char_code[CELL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
        begin
            rd_data_reg <= mem[rd_addr];
            mode_reg    <= rd_mode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            case (mode_reg)
                CELL_CURSOR: cell_res_reg <= CHAR_CURSOR;
                CELL_MEM:    cell_res_reg <= rd_data_reg;
                default:     cell_res_reg <= '0;
            endcase
            cursor_row_reg <= y_reg;
            cursor_col_reg <= x_reg;
            blink_on_reg   <= phase_reg;
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_COLUMNS:    prdata = PDATA_W'(columns_reg);
            REG_ROWS:       prdata = PDATA_W'(rows_reg);
            REG_CURSOR_EN:  prdata = PDATA_W'(cursor_en_reg);
            REG_BLINK_RATE: prdata = PDATA_W'(blink_rate_reg);
            default:        prdata = '0;
        endcase
    end

    assign cell_res   = cell_res_reg;
    assign cursor_row = cursor_row_reg;
    assign cursor_col = cursor_col_reg;
    assign blink_on   = blink_on_reg;

endmodule

### dv/text_console_buffer_tb.sv
`timescale 1ns / 1ps
// Testbench: drives console commands and registers, checks every response against a console model.
module text_console_buffer_tb;
    import tcb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 550;

    typedef struct packed {
        logic [CELL_W-1:0] cell_res;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              blink_on;
    } console_rsp_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    tcb_in_if  cmd_if ();
    tcb_out_if rsp_if ();

    text_console_buffer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // console model state
    logic [CELL_W-1:0]  screen_m [0:DEPTH-1];
    int unsigned        top_m;
    int unsigned        cx_m;
    int unsigned        cy_m;
    logic [BLINK_W-1:0] blink_cnt_m;
    logic [BLINK_W-1:0] blink_rate_m;
    logic               blink_ph_m;
    logic               cur_en_m;
    logic [NCOL_W-1:0]  cols_m;
    logic [NROW_W-1:0]  rows_m;

    console_rsp_t rsp_pending [$];
    console_rsp_t due_rsp;

    int unsigned cycle_cnt   = 0;
    int unsigned errors      = 0;
    int unsigned items_sent  = 0;
    int unsigned reads_sent  = 0;
    int unsigned scroll_cnt  = 0;
    int unsigned phases_run  = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_pct   = 0;
    int unsigned stall_left  = 0;
    int unsigned hold_req    = 0;
    int unsigned hold_left   = 0;
    bit          idle_on     = 0;
    bit          cmd_held    = 0;

    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("[text_console_buffer] ERROR");
            $finish;
        end
    end

    function automatic int unsigned used_cols();
        if (cols_m == 0)
            return 1;
        if (cols_m > MAX_COLUMNS)
            return MAX_COLUMNS;
        return 32'(cols_m);
    endfunction

    function automatic int unsigned used_rows();
        if (rows_m == 0)
            return 1;
        if (rows_m > MAX_ROWS)
            return MAX_ROWS;
        return 32'(rows_m);
    endfunction

    task automatic blank_screen();
        for (int i = 0; i < DEPTH; i++)
            screen_m[i] = '0;
        top_m = 0;
        cx_m  = 0;
        cy_m  = 0;
    endtask

    task automatic reset_console();
        cols_m       = RST_COLUMNS;
        rows_m       = RST_ROWS;
        cur_en_m     = 1'b1;
        blink_rate_m = RST_BLINK;
        blank_screen();
        blink_cnt_m  = RST_BLINK;
        blink_ph_m   = 1'b1;
    endtask

    task automatic advance_line();
        int unsigned nr;
        int unsigned old_top;
        nr   = used_rows();
        cx_m = 0;
        cy_m++;
        if (cy_m >= nr)
        begin
            old_top = top_m % nr;
            for (int i = 0; i < MAX_COLUMNS; i++)
                screen_m[old_top * MAX_COLUMNS + i] = '0;
            top_m = (old_top + 1) % nr;
            cy_m  = nr - 1;
            scroll_cnt++;
        end
    endtask

    task automatic console_apply(input kind_t k, input logic [CODE_W-1:0] code,
                                 input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                                 output console_rsp_t r);
        int unsigned       nc;
        int unsigned       nr;
        int unsigned       prow;
        logic [CELL_W-1:0] cell_v;
        nc     = used_cols();
        nr     = used_rows();
        cell_v = '0;
        case (k)
            KIND_PRINT:
            begin
                if (code >= CHAR_FIRST && code <= CHAR_LAST)
                begin
                    prow = (cy_m + top_m) % nr;
                    if (cx_m < nc)
                        screen_m[prow * MAX_COLUMNS + cx_m] = code[CELL_W-1:0];
                    cx_m++;
                end
                else if (code == CHAR_NEWLINE)
                    cx_m = nc;
                if (cx_m >= nc)
                    advance_line();
            end
            KIND_CLEAR:
                blank_screen();
            KIND_READ:
            begin
                if (rr >= nr || rc >= nc)
                    cell_v = '0;
                else if (cur_en_m && blink_ph_m && rr == cy_m && rc == cx_m)
                    cell_v = CHAR_CURSOR;
                else
                    cell_v = screen_m[((rr + top_m) % nr) * MAX_COLUMNS + rc];
            end
            default:
            begin
                if (cur_en_m)
                begin
                    if (blink_cnt_m == 0)
                    begin
                        blink_cnt_m = blink_rate_m;
                        blink_ph_m  = ~blink_ph_m;
                    end
                    else
                        blink_cnt_m = blink_cnt_m - BLINK_W'(1);
                end
            end
        endcase
        r.cell_res   = cell_v;
        r.cursor_row = cy_m[ROW_W-1:0];
        r.cursor_col = cx_m[COL_W-1:0];
        r.blink_on   = blink_ph_m;
    endtask

    task automatic apply_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] v);
        case (idx)
            REG_COLUMNS:
            begin
                cols_m = v[7:0];
                blank_screen();
            end
            REG_ROWS:
            begin
                rows_m = v[5:0];
                blank_screen();
            end
            REG_CURSOR_EN:
                cur_en_m = v[0];
            default:
            begin
                if (v[7:0] != 0)
                begin
                    blink_rate_m = v[7:0];
                    blink_cnt_m  = v[7:0];
                    blink_ph_m   = 1'b1;
                end
            end
        endcase
    endtask

    function automatic logic [PDATA_W-1:0] reg_value(input reg_idx_t idx);
        case (idx)
            REG_COLUMNS:   return PDATA_W'(cols_m);
            REG_ROWS:      return PDATA_W'(rows_m);
            REG_CURSOR_EN: return PDATA_W'(cur_en_m);
            default:       return PDATA_W'(blink_rate_m);
        endcase
    endfunction

    // Write one register; unused upper data bits carry noise.
    task automatic reg_write(input reg_idx_t idx, input int unsigned val);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] word;
        logic [PDATA_W-1:0] want;
        case (idx)
            REG_COLUMNS:   mask = 32'hFF;
            REG_ROWS:      mask = 32'h3F;
            REG_CURSOR_EN: mask = 32'h1;
            default:       mask = 32'hFF;
        endcase
        word    = ($urandom() & ~mask) | (val & mask);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_reg(idx, word);
        @(posedge clk);
        want = reg_value(idx);
        if (prdata !== want)
        begin
            $error("prdata: expected %0d, got %0d", want, prdata);
            errors++;
        end
        if (pready !== 1'b1)
        begin
            $error("pready: expected %0d, got %0d", 1'b1, pready);
            errors++;
        end
    endtask

    task automatic send_cmd(input kind_t k, input logic [CODE_W-1:0] code,
                            input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        console_rsp_t exp_r;
        int unsigned  gap;
        cmd_if.valid     <= 1'b1;
        cmd_if.kind      <= k;
        cmd_if.char_code <= code;
        cmd_if.read_row  <= rr;
        cmd_if.read_col  <= rc;
        cmd_held = 1'b1;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        console_apply(k, code, rr, rc, exp_r);
        rsp_pending.push_back(exp_r);
        items_sent++;
        if (k == KIND_READ)
            reads_sent++;
        if (idle_on)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = $urandom_range(1, 8);
                cmd_if.valid <= 1'b0;
                cmd_held = 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
        end
    endtask

    // Drop valid and wait until every response has transferred.
    task automatic drain();
        if (cmd_held)
        begin
            cmd_if.valid <= 1'b0;
            cmd_held = 1'b0;
        end
        while (rsp_pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_random();
        int unsigned       pick;
        int unsigned       sub;
        int unsigned       nc;
        int unsigned       nr;
        kind_t             k;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  rr;
        logic [COL_W-1:0]  rc;
        nc   = used_cols();
        nr   = used_rows();
        code = CODE_W'($urandom_range(255));
        rr   = ROW_W'($urandom_range(31));
        rc   = COL_W'($urandom_range(127));
        pick = $urandom_range(99);
        sub  = $urandom_range(99);
        if (pick < 50)
        begin
            k = KIND_PRINT;
            if (sub < 70)
                code = CODE_W'($urandom_range(32, 127));
            else if (sub < 80)
                code = CHAR_NEWLINE;
        end
        else if (pick < 78)
        begin
            k = KIND_READ;
            if (sub < 60)
            begin
                rr = ROW_W'($urandom_range(nr - 1));
                rc = COL_W'($urandom_range(nc - 1));
            end
            else if (sub < 80)
            begin
                rr = cy_m[ROW_W-1:0];
                rc = cx_m[COL_W-1:0];
            end
        end
        else if (pick < 97)
            k = KIND_TICK;
        else
            k = KIND_CLEAR;
        send_cmd(k, code, rr, rc);
    endtask

    task automatic run_phase(input int unsigned cols, input int unsigned rows,
                             input int unsigned en, input int unsigned rate,
                             input int unsigned n, input bit idle, input int unsigned stall);
        drain();
        reg_write(REG_COLUMNS, cols);
        reg_write(REG_ROWS, rows);
        reg_write(REG_CURSOR_EN, en);
        reg_write(REG_BLINK_RATE, rate);
        idle_on    = idle;
        stall_pct  = stall;
        burst_left = 0;
        repeat (n) send_random();
        phases_run++;
    endtask

    task automatic test_reset_state();
        idle_on   = 1'b0;
        stall_pct = 0;
        send_cmd(KIND_READ, 8'd0, 5'd0, 7'd0);
        send_cmd(KIND_READ, 8'd0, 5'd19, 7'd39);
        send_cmd(KIND_READ, 8'd0, 5'd20, 7'd0);
        send_cmd(KIND_READ, 8'd0, 5'd0, 7'd40);
        send_cmd(KIND_TICK, 8'd0, 5'd0, 7'd0);
    endtask

    task automatic test_print_wrap_scroll();
        drain();
        reg_write(REG_COLUMNS, 3);
        reg_write(REG_ROWS, 2);
        reg_write(REG_BLINK_RATE, 1);
        send_cmd(KIND_PRINT, 8'd65, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, CHAR_FIRST, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, CHAR_LAST, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, 8'd0, 5'd31, 7'd127);
        send_cmd(KIND_PRINT, 8'd31, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, 8'd128, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, 8'd255, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, CHAR_NEWLINE, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, 8'd66, 5'd0, 7'd0);
        send_cmd(KIND_PRINT, CHAR_NEWLINE, 5'd0, 7'd0);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 3; c++)
                send_cmd(KIND_READ, 8'd0, r[ROW_W-1:0], c[COL_W-1:0]);
        repeat (3) send_cmd(KIND_TICK, 8'd0, 5'd0, 7'd0);
        send_cmd(KIND_READ, 8'd0, cy_m[ROW_W-1:0], cx_m[COL_W-1:0]);
        send_cmd(KIND_CLEAR, 8'd0, 5'd0, 7'd0);
        send_cmd(KIND_READ, 8'd0, 5'd0, 7'd0);
    endtask

    task automatic test_size_extremes();
        run_phase(0, 0, 1, 1, 40, 1, 20);
        run_phase(255, 63, 1, 255, 40, 1, 20);
        run_phase(128, 32, 1, 2, 40, 0, 0);
        run_phase(1, 32, 1, 3, 50, 1, 25);
    endtask

    task automatic test_blink_control();
        run_phase(5, 3, 0, 4, 40, 1, 15);
        run_phase(6, 2, 1, 1, 30, 1, 30);
        drain();
        reg_write(REG_BLINK_RATE, 0);
        reg_write(REG_CURSOR_EN, 1);
        repeat (30) send_random();
    endtask

    task automatic test_backpressure();
        run_phase(4, 3, 1, 2, 0, 0, 0);
        hold_req = 80;
        repeat (40) send_random();
        drain();
        idle_on   = 1'b1;
        stall_pct = 60;
        repeat (30) send_random();
        drain();
    endtask

    task automatic test_random_mix();
        while (items_sent < ITEM_TARGET)
            run_phase($urandom_range(1, 12), $urandom_range(1, 6),
                      ($urandom_range(3) != 0), $urandom_range(1, 5),
                      $urandom_range(20, 50), ($urandom_range(1) != 0),
                      $urandom_range(0, 40));
    endtask

    // receiver: random short stalls plus an occasional long hold
    initial
    begin
        rsp_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                if (stall_pct != 0 && $urandom_range(99) < stall_pct)
                    stall_left = $urandom_range(1, 5);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            if (rsp_pending.size() == 0)
            begin
                $error("response transfer with nothing pending: cell_res %0d row %0d col %0d",
                       rsp_if.cell_res, rsp_if.cursor_row, rsp_if.cursor_col);
                errors++;
            end
            else
            begin
                due_rsp = rsp_pending.pop_front();
                if (rsp_if.cell_res !== due_rsp.cell_res)
                begin
                    $error("cell_res: expected %0d, got %0d", due_rsp.cell_res, rsp_if.cell_res);
                    errors++;
                end
                if (rsp_if.cursor_row !== due_rsp.cursor_row)
                begin
                    $error("cursor_row: expected %0d, got %0d",
                           due_rsp.cursor_row, rsp_if.cursor_row);
                    errors++;
                end
                if (rsp_if.cursor_col !== due_rsp.cursor_col)
                begin
                    $error("cursor_col: expected %0d, got %0d",
                           due_rsp.cursor_col, rsp_if.cursor_col);
                    errors++;
                end
                if (rsp_if.blink_on !== due_rsp.blink_on)
                begin
                    $error("blink_on: expected %0d, got %0d", due_rsp.blink_on, rsp_if.blink_on);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        cmd_if.valid     = 1'b0;
        cmd_if.kind      = KIND_PRINT;
        cmd_if.char_code = '0;
        cmd_if.read_row  = '0;
        cmd_if.read_col  = '0;
        reset_console();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_print_wrap_scroll();
        test_size_extremes();
        test_blink_control();
        test_backpressure();
        test_random_mix();

        drain();
        repeat (8) @(posedge clk);
        if (rsp_pending.size() != 0)
        begin
            $error("%0d responses never arrived", rsp_pending.size());
            errors++;
        end
        $display("covered %0d commands (%0d cell reads, %0d scrolls) over %0d register settings",
                 items_sent, reads_sent, scroll_cnt, phases_run);
        $display("mismatches seen: %0d", errors);
        if (errors == 0)
            $display("[text_console_buffer] OK");
        else
            $display("[text_console_buffer] ERROR");
        $finish;
    end

endmodule
